// ===== src/xcrc_pkg.sv =====
package xcrc_pkg;

  // Session defaults
  localparam int unsigned PayloadBytesDef = 128;
  localparam logic [7:0]  MaxErrorsRst    = 8'd10;

  // Operation codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Session status
  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_CANCELLED = 2'd2;
  localparam logic [1:0] ST_ABORTED   = 2'd3;

  // Line characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcMsb   = 16'h8000;
  localparam logic [7:0]  CompSum  = 8'd255;
  localparam logic [7:0]  ErrSat   = 8'd255;

  // One result item
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] byte_value;
    logic [6:0] byte_offset;
    logic [7:0] packet_number;
    logic       packet_accepted;
    logic [1:0] session_status;
    logic       last;
  } xcrc_res_t;

  // Results caused by one input item (zero to two)
  typedef struct packed {
    logic [1:0] count;
    xcrc_res_t  res0;
    xcrc_res_t  res1;
  } xcrc_step_t;

  // CRC-16/XMODEM update with one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/xcrc_if.sv =====
// Input channel: operation and received byte
interface xcrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// Result channel
interface xcrc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] byte_value;
  logic [6:0] byte_offset;
  logic [7:0] packet_number;
  logic       packet_accepted;
  logic [1:0] session_status;
  logic       last;

  modport source (output valid, output result_kind, output byte_value, output byte_offset,
                  output packet_number, output packet_accepted, output session_status,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input byte_value, input byte_offset,
                  input packet_number, input packet_accepted, input session_status,
                  input last, output ready);
endinterface

// ===== src/xmodem_crc_packet_receiver_unit.sv =====
// XMODEM-CRC receiver, one line event per input transfer.
// Input channel in_i carries an operation (start session, received byte,
// receive timeout) and the received byte. Output channel out_o carries result
// items: tentative data bytes, reply bytes to transmit (ACK, NAK, CAN) and
// session end reports; last marks the final result of one input.
// cfg_we_i/cfg_data_i write max_errors, the error count that aborts a session.
// The first result of an input appears on out_o the cycle after its transfer.
// Throughput: one input per cycle while the downstream is ready and each input
// yields at most one result; the two-CAN abort yields two results. The
// two-entry result buffer sets this: an input is taken when the buffer is empty
// or its single entry leaves in the same cycle.
// Reset: no session is open, expected packet 1, max_errors 10, buffer empty.
// When the downstream stalls, results wait in the buffer and in_i.ready drops
// until there is room for the next input's results; nothing is lost.
module xmodem_crc_packet_receiver_unit #(
  parameter int unsigned PAYLOAD_BYTES = xcrc_pkg::PayloadBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  xcrc_in_if.sink           in_i,
  xcrc_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i
);
  import xcrc_pkg::*;

  logic [7:0] max_errors_q;
  logic       take;
  logic       room;
  xcrc_step_t step;
  xcrc_res_t  head;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_errors_q <= MaxErrorsRst;
    end else if (cfg_we_i) begin
      max_errors_q <= cfg_data_i;
    end
  end

  assign take       = in_i.valid && room;
  assign in_i.ready = room;

  xcrc_rx_fsm #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .op_i         (in_i.operation),
    .byte_i       (in_i.rx_byte),
    .max_errors_i (max_errors_q),
    .step_o       (step)
  );

  xcrc_rx_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .step_i      (step),
    .pop_ready_i (out_o.ready),
    .room_o      (room),
    .valid_o     (out_o.valid),
    .head_o      (head)
  );

  // Result fields
  assign out_o.result_kind     = head.result_kind;
  assign out_o.byte_value      = head.byte_value;
  assign out_o.byte_offset     = head.byte_offset;
  assign out_o.packet_number   = head.packet_number;
  assign out_o.packet_accepted = head.packet_accepted;
  assign out_o.session_status  = head.session_status;
  assign out_o.last            = head.last;

endmodule

// ===== src/xcrc_rx_fsm.sv =====
module xcrc_rx_fsm #(
  parameter int unsigned PAYLOAD_BYTES = xcrc_pkg::PayloadBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          max_errors_i,
  output xcrc_pkg::xcrc_step_t step_o
);
  import xcrc_pkg::*;

  localparam int unsigned CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(PAYLOAD_BYTES - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_NUM, PH_COMP, PH_DATA, PH_CRC_HI, PH_CRC_LO
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      exp_num_q, exp_num_d;
  logic [7:0]      rcv_num_q, rcv_num_d;
  logic            num_bad_q, num_bad_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_hi_q, crc_hi_d;
  logic [7:0]      err_q, err_d;

  logic [7:0]      err_inc;
  logic            abort;
  logic [CntW+6:0] cnt_ext;
  logic [7:0]      comp_sum;
  xcrc_res_t       blank;

  assign err_inc  = (err_q != ErrSat) ? (err_q + 8'd1) : err_q;
  assign abort    = (err_inc >= max_errors_i);
  assign cnt_ext  = {7'd0, cnt_q};
  assign comp_sum = rcv_num_q + byte_i;

  // Next state and results for the presented item
  always_comb begin
    phase_d   = phase_q;
    exp_num_d = exp_num_q;
    rcv_num_d = rcv_num_q;
    num_bad_d = num_bad_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    err_d     = err_q;

    blank = '0;
    blank.packet_number = exp_num_q;
    blank.last          = 1'b1;
    step_o       = '0;
    step_o.res0  = blank;
    step_o.res1  = blank;

    case (op_i)
      OP_START: begin
        phase_d   = PH_HEADER;
        exp_num_d = 8'd1;
        rcv_num_d = 8'd0;
        num_bad_d = 1'b0;
        cnt_d     = '0;
        crc_d     = '0;
        crc_hi_d  = '0;
        err_d     = '0;
      end
      OP_TIMEOUT: begin
        if (phase_q inside {PH_NUM, PH_COMP, PH_DATA, PH_CRC_HI, PH_CRC_LO}) begin
          err_d = err_inc;
          step_o.res0.result_kind = KIND_REPLY;
          if (abort) begin
            step_o.count = 2'd2;
            step_o.res0.byte_value     = CH_CAN;
            step_o.res0.session_status = ST_ABORTED;
            step_o.res0.last           = 1'b0;
            step_o.res1.result_kind    = KIND_REPLY;
            step_o.res1.byte_value     = CH_CAN;
            step_o.res1.session_status = ST_ABORTED;
            phase_d = PH_IDLE;
          end else begin
            step_o.count = 2'd1;
            step_o.res0.byte_value = CH_NAK;
            phase_d = PH_HEADER;
          end
        end
      end
      OP_BYTE: begin
        case (phase_q)
          PH_HEADER: begin
            if (byte_i == CH_SOH) begin
              phase_d = PH_NUM;
            end else if (byte_i == CH_EOT) begin
              step_o.count = 2'd1;
              step_o.res0.result_kind    = KIND_REPLY;
              step_o.res0.byte_value     = CH_ACK;
              step_o.res0.session_status = ST_DONE;
              phase_d = PH_IDLE;
            end else if (byte_i == CH_CAN) begin
              step_o.count = 2'd1;
              step_o.res0.result_kind    = KIND_END;
              step_o.res0.session_status = ST_CANCELLED;
              phase_d = PH_IDLE;
            end else begin
              // bad header: error reply with the expected number
              err_d = err_inc;
              step_o.res0.result_kind = KIND_REPLY;
              if (abort) begin
                step_o.count = 2'd2;
                step_o.res0.byte_value     = CH_CAN;
                step_o.res0.session_status = ST_ABORTED;
                step_o.res0.last           = 1'b0;
                step_o.res1.result_kind    = KIND_REPLY;
                step_o.res1.byte_value     = CH_CAN;
                step_o.res1.session_status = ST_ABORTED;
                phase_d = PH_IDLE;
              end else begin
                step_o.count = 2'd1;
                step_o.res0.byte_value = CH_NAK;
              end
            end
          end
          PH_NUM: begin
            rcv_num_d = byte_i;
            num_bad_d = (byte_i != exp_num_q);
            phase_d   = PH_COMP;
          end
          PH_COMP: begin
            if (comp_sum != CompSum || rcv_num_q > CompSum - byte_i) begin
              num_bad_d = 1'b1;
            end
            cnt_d   = '0;
            crc_d   = '0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            crc_d = crc_update(crc_q, byte_i);
            step_o.count = 2'd1;
            step_o.res0.result_kind   = KIND_DATA;
            step_o.res0.byte_value    = byte_i;
            step_o.res0.byte_offset   = cnt_ext[6:0];
            step_o.res0.packet_number = rcv_num_q;
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == CntLast) begin
              phase_d = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_hi_d = byte_i;
            phase_d  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            step_o.res0.result_kind   = KIND_REPLY;
            step_o.res0.packet_number = rcv_num_q;
            if (!num_bad_q && {crc_hi_q, byte_i} == crc_q) begin
              step_o.count = 2'd1;
              step_o.res0.byte_value      = CH_ACK;
              step_o.res0.packet_accepted = 1'b1;
              exp_num_d = exp_num_q + 8'd1;
              phase_d   = PH_HEADER;
            end else begin
              err_d = err_inc;
              if (abort) begin
                step_o.count = 2'd2;
                step_o.res0.byte_value     = CH_CAN;
                step_o.res0.session_status = ST_ABORTED;
                step_o.res0.last           = 1'b0;
                step_o.res1.result_kind    = KIND_REPLY;
                step_o.res1.byte_value     = CH_CAN;
                step_o.res1.packet_number  = rcv_num_q;
                step_o.res1.session_status = ST_ABORTED;
                phase_d = PH_IDLE;
              end else begin
                step_o.count = 2'd1;
                step_o.res0.byte_value = CH_NAK;
                phase_d = PH_HEADER;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      exp_num_q <= 8'd1;
      rcv_num_q <= 8'd0;
      num_bad_q <= 1'b0;
      cnt_q     <= '0;
      crc_q     <= '0;
      crc_hi_q  <= '0;
      err_q     <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      exp_num_q <= exp_num_d;
      rcv_num_q <= rcv_num_d;
      num_bad_q <= num_bad_d;
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== src/xcrc_rx_obuf.sv =====
module xcrc_rx_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  xcrc_pkg::xcrc_step_t step_i,
  input  logic                 pop_ready_i,
  output logic                 room_o,
  output logic                 valid_o,
  output xcrc_pkg::xcrc_res_t  head_o
);
  import xcrc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  xcrc_res_t  slot0_q, slot0_d;
  xcrc_res_t  slot1_q, slot1_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot0_q;
  assign pop     = valid_o && pop_ready_i;
  // room for two results once the head leaves this cycle
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop_ready_i);

  // Load on push (buffer is empty after pop), else shift on pop
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
    if (push_i) begin
      cnt_d   = step_i.count;
      slot0_d = step_i.res0;
      slot1_d = step_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// ===== test/xmodem_crc_packet_receiver_unit_tb.sv =====
module xmodem_crc_packet_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcrc_pkg::*;

  localparam int unsigned PayloadBytes = PayloadBytesDef;
  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int          ItemTarget   = 900;
  localparam int          CalmAfter    = 750;

  // Receiver phases of the line protocol
  typedef enum logic [3:0] {
    RX_IDLE, RX_HEADER, RX_NUM, RX_COMP, RX_DATA, RX_CRC_HI, RX_CRC_LO
  } rx_phase_e;

  typedef enum int {
    FLAW_NONE, FLAW_NUMBER, FLAW_COMPLEMENT, FLAW_CRC, FLAW_TIMEOUT
  } pkt_flaw_e;

  // One directed row; want is used only when typed is set
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       typed;
    xcrc_res_t  want;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam stim_row_t DirRows [NumRows] = '{
    // no session yet: everything ignored
    '{OP_BYTE,    CH_SOH, 1'b0, '0},
    '{OP_TIMEOUT, 8'h00,  1'b0, '0},
    '{OpUnused,   8'hFF,  1'b0, '0},
    '{OP_START,   8'hA5,  1'b0, '0},
    // timeout while waiting for a header is ignored
    '{OP_TIMEOUT, 8'h00,  1'b0, '0},
    '{OP_BYTE,    8'hFF,  1'b1, '{KIND_REPLY, CH_NAK, 7'd0, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    '{OP_BYTE,    CH_SOH, 1'b0, '0},
    '{OP_BYTE,    8'h01,  1'b0, '0},
    '{OP_BYTE,    8'hFE,  1'b0, '0},
    '{OP_BYTE,    8'h00,  1'b1, '{KIND_DATA, 8'h00, 7'd0, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    '{OP_BYTE,    8'hFF,  1'b1, '{KIND_DATA, 8'hFF, 7'd1, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    // timeout inside a packet
    '{OP_TIMEOUT, 8'h00,  1'b1, '{KIND_REPLY, CH_NAK, 7'd0, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    // wrong packet number, data still passed on with the received number
    '{OP_BYTE,    CH_SOH, 1'b0, '0},
    '{OP_BYTE,    8'hFF,  1'b0, '0},
    '{OP_BYTE,    8'h00,  1'b0, '0},
    '{OP_BYTE,    8'h80,  1'b1, '{KIND_DATA, 8'h80, 7'd0, 8'hFF, 1'b0, ST_RUNNING, 1'b1}},
    '{OP_TIMEOUT, 8'h00,  1'b1, '{KIND_REPLY, CH_NAK, 7'd0, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    '{OP_BYTE,    CH_EOT, 1'b1, '{KIND_REPLY, CH_ACK, 7'd0, 8'd1, 1'b0, ST_DONE, 1'b1}},
    '{OP_START,   8'h00,  1'b0, '0},
    '{OP_BYTE,    CH_CAN, 1'b1, '{KIND_END, 8'h00, 7'd0, 8'd1, 1'b0, ST_CANCELLED, 1'b1}},
    '{OP_BYTE,    CH_SOH, 1'b0, '0},
    '{OP_START,   8'h00,  1'b0, '0},
    '{OP_BYTE,    8'h7F,  1'b1, '{KIND_REPLY, CH_NAK, 7'd0, 8'd1, 1'b0, ST_RUNNING, 1'b1}},
    // restart in the middle of a session
    '{OP_START,   8'h3C,  1'b0, '0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  xcrc_in_if  in_if ();
  xcrc_out_if out_if ();

  xmodem_crc_packet_receiver_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Receiver model state
  rx_phase_e   rx_phase;
  logic [7:0]  next_pkt;
  logic [7:0]  got_pkt;
  logic        pkt_bad;
  int          data_idx;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  logic [7:0]  err_cnt;
  logic [7:0]  err_limit;

  xcrc_res_t step_out [$];
  xcrc_res_t pending_results [$];
  int        mismatch_count;
  int        items_sent;
  bit        calm;

  // CRC-16/XMODEM, one input bit at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic xcrc_res_t make_res(input logic [1:0] kind, input logic [7:0] value,
                                         input logic [6:0] offset, input logic [7:0] num,
                                         input logic acc, input logic [1:0] status,
                                         input logic lst);
    xcrc_res_t r;
    r.result_kind     = kind;
    r.byte_value      = value;
    r.byte_offset     = offset;
    r.packet_number   = num;
    r.packet_accepted = acc;
    r.session_status  = status;
    r.last            = lst;
    return r;
  endfunction

  // Error verdict: NAK, or a double CAN once the limit is reached
  task automatic error_verdict(input logic [7:0] num);
    if (err_cnt != ErrSat) err_cnt++;
    if (err_cnt >= err_limit) begin
      step_out.push_back(make_res(KIND_REPLY, CH_CAN, '0, num, 1'b0, ST_ABORTED, 1'b0));
      step_out.push_back(make_res(KIND_REPLY, CH_CAN, '0, num, 1'b0, ST_ABORTED, 1'b1));
      rx_phase = RX_IDLE;
    end else begin
      step_out.push_back(make_res(KIND_REPLY, CH_NAK, '0, num, 1'b0, ST_RUNNING, 1'b1));
      rx_phase = RX_HEADER;
    end
  endtask

  // Advance the model by one accepted input; results land in step_out
  task automatic rx_predict(input logic [1:0] op, input logic [7:0] b);
    logic [15:0] crc_rx;
    step_out.delete();
    case (op)
      OP_START: begin
        rx_phase = RX_HEADER;
        next_pkt = 8'd1;
        got_pkt  = '0;
        pkt_bad  = 1'b0;
        data_idx = 0;
        crc_acc  = '0;
        crc_hi   = '0;
        err_cnt  = '0;
      end
      OP_TIMEOUT: begin
        if (rx_phase >= RX_NUM && rx_phase <= RX_CRC_LO) error_verdict(next_pkt);
      end
      OP_BYTE: begin
        case (rx_phase)
          RX_HEADER: begin
            if (b == CH_SOH) begin
              rx_phase = RX_NUM;
            end else if (b == CH_EOT) begin
              step_out.push_back(make_res(KIND_REPLY, CH_ACK, '0, next_pkt, 1'b0, ST_DONE, 1'b1));
              rx_phase = RX_IDLE;
            end else if (b == CH_CAN) begin
              step_out.push_back(make_res(KIND_END, '0, '0, next_pkt, 1'b0, ST_CANCELLED, 1'b1));
              rx_phase = RX_IDLE;
            end else begin
              error_verdict(next_pkt);
            end
          end
          RX_NUM: begin
            got_pkt  = b;
            pkt_bad  = (b != next_pkt);
            rx_phase = RX_COMP;
          end
          RX_COMP: begin
            if (9'(got_pkt) + 9'(b) != 9'(CompSum)) pkt_bad = 1'b1;
            data_idx = 0;
            crc_acc  = '0;
            rx_phase = RX_DATA;
          end
          RX_DATA: begin
            crc_acc = crc16_step(crc_acc, b);
            step_out.push_back(make_res(KIND_DATA, b, data_idx[6:0], got_pkt, 1'b0,
                                        ST_RUNNING, 1'b1));
            data_idx++;
            if (data_idx >= PayloadBytes) rx_phase = RX_CRC_HI;
          end
          RX_CRC_HI: begin
            crc_hi   = b;
            rx_phase = RX_CRC_LO;
          end
          RX_CRC_LO: begin
            crc_rx = {crc_hi, b};
            if (!pkt_bad && crc_rx == crc_acc) begin
              step_out.push_back(make_res(KIND_REPLY, CH_ACK, '0, got_pkt, 1'b1,
                                          ST_RUNNING, 1'b1));
              next_pkt = next_pkt + 8'd1;
              rx_phase = RX_HEADER;
            end else begin
              error_verdict(got_pkt);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // One input transfer, with an occasional idle burst in front
  task automatic send(input logic [1:0] op, input logic [7:0] b,
                      input logic typed = 1'b0, input xcrc_res_t want = '0);
    bit taken;
    bit counts;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.rx_byte   <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end
    counts = (op == OP_START) ||
             (op != OpUnused && rx_phase != RX_IDLE &&
              !(op == OP_TIMEOUT && rx_phase == RX_HEADER));
    rx_predict(op, b);
    if (typed) pending_results.push_back(want);
    else foreach (step_out[i]) pending_results.push_back(step_out[i]);
    if (counts) items_sent++;
    if (items_sent >= CalmAfter) calm = 1'b1;
  endtask

  // Hold the sender until every expected result has left the block
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [7:0] v);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    err_limit = v;
  endtask

  function automatic logic [7:0] junk_header();
    logic [7:0] v;
    do v = 8'($urandom); while (v == CH_SOH || v == CH_EOT || v == CH_CAN);
    return v;
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Whole packet: SOH, number, complement, payload, CRC; optionally flawed
  task automatic send_packet(input pkt_flaw_e flaw);
    logic [7:0]  frame [PayloadBytes + 4];
    logic [15:0] crc;
    int          cut;
    crc = '0;
    frame[0] = next_pkt;
    if (flaw == FLAW_NUMBER) frame[0] = next_pkt + 8'($urandom_range(1, 255));
    frame[1] = ~frame[0];
    if (flaw == FLAW_COMPLEMENT) frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < PayloadBytes; i++) begin
      frame[i + 2] = rand_data();
      crc = crc16_step(crc, frame[i + 2]);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    frame[PayloadBytes + 2] = crc[15:8];
    frame[PayloadBytes + 3] = crc[7:0];
    cut = (flaw == FLAW_TIMEOUT) ? $urandom_range(0, PayloadBytes + 3) : PayloadBytes + 4;
    send(OP_BYTE, CH_SOH);
    for (int i = 0; i < cut; i++) send(OP_BYTE, frame[i]);
    if (flaw == FLAW_TIMEOUT) send(OP_TIMEOUT, 8'($urandom));
  endtask

  // Result checking against the oldest expectation
  xcrc_res_t seen;
  xcrc_res_t want_res;

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen = '{out_if.result_kind, out_if.byte_value, out_if.byte_offset,
               out_if.packet_number, out_if.packet_accepted, out_if.session_status,
               out_if.last};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with none expected, actual kind %0d value %02h",
                 $time, seen.result_kind, seen.byte_value);
      end else begin
        want_res = pending_results.pop_front();
        check_field("result_kind", want_res.result_kind, seen.result_kind);
        check_field("byte_value", want_res.byte_value, seen.byte_value);
        check_field("byte_offset", want_res.byte_offset, seen.byte_offset);
        check_field("packet_number", want_res.packet_number, seen.packet_number);
        check_field("packet_accepted", want_res.packet_accepted, seen.packet_accepted);
        check_field("session_status", want_res.session_status, seen.session_status);
        check_field("last", want_res.last, seen.last);
      end
    end
  end

  // Result side: ready with random stall bursts
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    int        events;
    int        pick;
    logic [1:0] idle_op;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_START;
    in_if.rx_byte   <= '0;
    mismatch_count = 0;
    items_sent     = 0;
    calm           = 1'b0;
    rx_phase       = RX_IDLE;
    next_pkt       = 8'd1;
    got_pkt        = '0;
    pkt_bad        = 1'b0;
    data_idx       = 0;
    crc_acc        = '0;
    crc_hi         = '0;
    err_cnt        = '0;
    err_limit      = MaxErrorsRst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at the reset limit
    for (int i = 0; i < NumRows; i++) begin
      send(DirRows[i].op, DirRows[i].data, DirRows[i].typed, DirRows[i].want);
    end

    // Limit of zero: first error aborts; sender held mid-packet first
    set_limit(8'd0);
    send(OP_START, 8'h00);
    send(OP_BYTE, CH_SOH);
    send(OP_BYTE, 8'h01);
    wait_drained();
    send(OP_TIMEOUT, 8'h00);

    // Limit of one: bad header aborts
    set_limit(8'd1);
    send(OP_START, 8'h00);
    send(OP_BYTE, junk_header());

    // Highest limit: errors pile up to the top before the abort
    set_limit(8'd255);
    send(OP_START, 8'h00);
    while (rx_phase != RX_IDLE) send(OP_BYTE, junk_header());

    // Random sessions
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_limit(8'd1);
          1:       set_limit(8'd2);
          2:       set_limit(8'd3);
          3:       set_limit(8'd255);
          default: set_limit(8'($urandom_range(1, 255)));
        endcase
      end
      send(OP_START, 8'($urandom));
      events = $urandom_range(1, 6);
      for (int e = 0; e < events && rx_phase != RX_IDLE && items_sent < ItemTarget; e++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      send_packet(FLAW_NONE);
        else if (pick < 52) send_packet(FLAW_NUMBER);
        else if (pick < 59) send_packet(FLAW_COMPLEMENT);
        else if (pick < 66) send_packet(FLAW_CRC);
        else if (pick < 76) send_packet(FLAW_TIMEOUT);
        else if (pick < 84) send(OP_BYTE, junk_header());
        else if (pick < 90) send(OP_TIMEOUT, 8'($urandom));
        else if (pick < 93) send(OpUnused, 8'($urandom));
        else if (pick < 96) send(OP_START, 8'($urandom));
        else                wait_drained();
      end
      // close the session: EOT, sender cancel, or errors up to the abort
      if (rx_phase != RX_IDLE) begin
        pick = $urandom_range(0, 2);
        if (pick == 0 && err_limit <= 8'd8) begin
          while (rx_phase != RX_IDLE) send(OP_BYTE, junk_header());
        end else if (pick == 1) begin
          send(OP_BYTE, CH_CAN);
        end else begin
          while (rx_phase != RX_HEADER) send(OP_TIMEOUT, 8'h00);
          send(OP_BYTE, CH_EOT);
        end
      end
      // up to two inputs with no session open
      repeat ($urandom_range(0, 2)) begin
        idle_op = 2'($urandom_range(1, 3));
        send(idle_op, 8'($urandom));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
src/xcrc_pkg.sv
src/xcrc_if.sv
src/xcrc_rx_fsm.sv
src/xcrc_rx_obuf.sv
src/xmodem_crc_packet_receiver_unit.sv
test/xmodem_crc_packet_receiver_unit_tb.sv
